/* hw/rtl/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Sizes, widths and types shared by the cache unit.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(16);

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [IDX_W-1:0]        t_rank;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic signed [VAL_W-1:0] t_val;

endpackage

/* hw/rtl/lru_key_value_cache_unit.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache unit
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+---------------------------------
//  request   | start / busy                  | i_operation, i_lookup_key,
//            |                               | i_write_value
//  result    | o_result_valid (strobe)       | o_hit, o_read_value
//  config    | i_cfg_valid / o_cfg_ready     | i_cfg_data (capacity in use)
//
//  One request per cycle; the result strobe is registered from r_req_vld,
//  the registered start. The request register feeds a parallel key compare,
//  rank update and the result register; busy never rises.
//  Reset clears valid bits, recency ranks and the fill count, and sets the
//  capacity to 16. Key and value stores are not cleared.
//  The receiver cannot stall the result; config is always ready.
//
module lru_key_value_cache_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_operation,
    input  logic signed [31:0]        i_lookup_key,
    input  logic signed [31:0]        i_write_value,
    output logic                      o_result_valid,
    output logic                      o_hit,
    output logic signed [31:0]        o_read_value,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [4:0]                i_cfg_data
);

    localparam int N = lkvc_pkg::ENTRIES;

    // request register
    logic             r_req_vld;
    lkvc_pkg::t_op    r_op;
    lkvc_pkg::t_key   r_key;
    lkvc_pkg::t_val   r_val;

    // cache state
    logic [N-1:0]     r_valid;
    lkvc_pkg::t_rank  r_rank [N];
    lkvc_pkg::t_key   r_key_mem [N];
    lkvc_pkg::t_val   r_val_mem [N];
    lkvc_pkg::t_cnt   r_entries_used;
    logic [lkvc_pkg::CFG_W-1:0] r_capacity;

    // result register
    logic             r_result_valid;
    logic             r_hit;
    lkvc_pkg::t_val   r_read_value;

    // lookup and decision
    logic [N-1:0]     hit_vec;
    logic             hit_any;
    lkvc_pkg::t_idx   hit_idx;
    lkvc_pkg::t_idx   free_idx;
    lkvc_pkg::t_idx   victim_idx;
    lkvc_pkg::t_rank  lru_rank;
    lkvc_pkg::t_cnt   eff_cap;
    logic             can_fill;

    logic             do_promote;
    logic             age_all;
    lkvc_pkg::t_idx   promote_idx;
    lkvc_pkg::t_rank  promote_rank;
    logic             wr_key;
    logic             wr_val;
    lkvc_pkg::t_idx   wr_idx;
    logic             set_valid;
    logic             inc_used;

    logic [N-1:0]     n_valid;
    lkvc_pkg::t_rank  n_rank [N];
    lkvc_pkg::t_cnt   n_entries_used;
    logic             n_hit;
    lkvc_pkg::t_val   n_read_value;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign o_result_valid = r_result_valid;
    assign o_hit          = r_hit;
    assign o_read_value   = r_read_value;

    // parallel key compare and priority picks
    always_comb begin
        hit_vec    = '0;
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        lru_rank   = lkvc_pkg::t_rank'(r_entries_used - lkvc_pkg::t_cnt'(1));
        for (int i = N - 1; i >= 0; i--) begin
            hit_vec[i] = r_valid[i] && (r_key_mem[i] == r_key);
            if (hit_vec[i]) begin
                hit_idx = lkvc_pkg::t_idx'(i);
            end
            if (!r_valid[i]) begin
                free_idx = lkvc_pkg::t_idx'(i);
            end
            if (r_valid[i] && (r_rank[i] == lru_rank)) begin
                victim_idx = lkvc_pkg::t_idx'(i);
            end
        end
        hit_any = |hit_vec;
    end

    // clamp capacity to 1..ENTRIES
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = lkvc_pkg::t_cnt'(1);
        end else if (int'(r_capacity) > N) begin
            eff_cap = lkvc_pkg::t_cnt'(N);
        end else begin
            eff_cap = lkvc_pkg::t_cnt'(r_capacity);
        end
        can_fill = r_entries_used < eff_cap;
    end

    // decide the update for the registered request
    always_comb begin
        do_promote   = 1'b0;
        age_all      = 1'b0;
        promote_idx  = hit_idx;
        promote_rank = r_rank[hit_idx];
        wr_key       = 1'b0;
        wr_val       = 1'b0;
        wr_idx       = hit_idx;
        set_valid    = 1'b0;
        inc_used     = 1'b0;
        n_hit        = hit_any;
        n_read_value = '0;
        if (r_req_vld) begin
            if (hit_any) begin
                do_promote = 1'b1;
                wr_val     = (r_op == lkvc_pkg::OP_PUT);
                if (r_op == lkvc_pkg::OP_GET) begin
                    n_read_value = r_val_mem[hit_idx];
                end
            end else if (r_op == lkvc_pkg::OP_GET) begin
                n_read_value = '1;
            end else if (can_fill) begin
                // fill the lowest free entry, age every valid one
                do_promote  = 1'b1;
                age_all     = 1'b1;
                promote_idx = free_idx;
                wr_key      = 1'b1;
                wr_val      = 1'b1;
                wr_idx      = free_idx;
                set_valid   = 1'b1;
                inc_used    = 1'b1;
            end else begin
                // replace the least recent entry
                do_promote   = 1'b1;
                promote_idx  = victim_idx;
                promote_rank = lru_rank;
                wr_key       = 1'b1;
                wr_val       = 1'b1;
                wr_idx       = victim_idx;
            end
        end
    end

    // rank and valid next state
    always_comb begin
        n_valid        = r_valid;
        n_entries_used = r_entries_used + lkvc_pkg::t_cnt'(inc_used);
        for (int i = 0; i < N; i++) begin
            n_rank[i] = r_rank[i];
            if (do_promote) begin
                if (lkvc_pkg::t_idx'(i) == promote_idx) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (age_all || (r_rank[i] < promote_rank))) begin
                    n_rank[i] = r_rank[i] + lkvc_pkg::t_rank'(1);
                end
            end
        end
        if (set_valid) begin
            n_valid[free_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld      <= 1'b0;
            r_result_valid <= 1'b0;
            r_valid        <= '0;
            r_entries_used <= '0;
            r_capacity     <= lkvc_pkg::CAPACITY_RESET;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_req_vld      <= start && !busy;
            r_result_valid <= r_req_vld;
            r_valid        <= n_valid;
            r_entries_used <= n_entries_used;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= n_rank[i];
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    // payload and stores, no reset
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op  <= lkvc_pkg::t_op'(i_operation);
            r_key <= i_lookup_key;
            r_val <= i_write_value;
        end
        if (r_req_vld) begin
            r_hit        <= n_hit;
            r_read_value <= n_read_value;
        end
        if (wr_key) begin
            r_key_mem[wr_idx] <= r_key;
        end
        if (wr_val) begin
            r_val_mem[wr_idx] <= r_val;
        end
    end

`ifndef SYNTHESIS
    a_used_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_entries_used))
        else $error("fill count disagrees with valid bits");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_entries_used) <= N)
        else $error("fill count exceeds entries");

    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_vld |=> o_result_valid)
        else $error("request produced no result");

    a_no_hit_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_vld && (r_valid == '0)) |=> !o_hit)
        else $error("hit reported with no valid entries");

    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_vld |-> $onehot0(hit_vec))
        else $error("key matches more than one entry");
`endif

endmodule
